[rtl/tsc_pkg.sv]
// ----------------------------------------------------------------------------
// tsc_pkg
// shared widths, register indexes and reset values for the tile slot cache
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int unsigned CacheEntriesDef = 128;

  // input field and result widths
  localparam int unsigned GLYPH_W  = 13;
  localparam int unsigned COLOUR_W = 4;
  localparam int unsigned SPEC_W   = 8;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned TILE_W   = 12;
  localparam int unsigned KEY_W    = GLYPH_W + COLOUR_W + SPEC_W + CHAR_W + TILE_W;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned TIDX_W   = 12;

  // configuration registers
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned TPE_W      = 5;
  localparam int unsigned EIU_W      = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TILES_PER_ENTRY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE  = 1'd1;

  localparam logic [TPE_W-1:0] TPE_RESET = 5'd4;
  localparam logic [EIU_W-1:0] EIU_RESET = 8'd127;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [STAMP_W-1:0] stamp_t;

endpackage

[rtl/tsc_ram.sv]
// ----------------------------------------------------------------------------
// tsc_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tsc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tile_slot_cache_lru.sv]
// ----------------------------------------------------------------------------
// tile_slot_cache_lru
// fully associative tile slot cache with least recently used replacement
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. The block then
// walks the n active slots (entries_in_use, clamped to 1..CACHE_ENTRIES), one
// slot per cycle through the read port of the key and time stamp memories,
// looking for a matching key, the first empty slot and the oldest slot at
// the same time. busy_o stays high through the scan, drain and update states,
// and the result is shown on hit_o, slot_o and tile_index_o for the single cycle
// in which done_o is high, registered from the update state. done_o cannot be
// held off, so the result must be captured in that cycle; a new request may
// be issued in the same cycle. Configuration writes are applied at once and
// should only be made while busy_o is low.
module tile_slot_cache_lru
  import tsc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = CacheEntriesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [GLYPH_W-1:0]    glyph_i,
  input  logic [COLOUR_W-1:0]   colour_i,
  input  logic [SPEC_W-1:0]     special_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic [TILE_W-1:0]     tile_number_i,
  input  logic [STAMP_W-1:0]    now_i,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // result
  output logic                  done_o,
  output logic                  hit_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic [TIDX_W-1:0]     tile_index_o
);

  localparam int unsigned IDX_W  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CNT_RAW = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned CNT_W  = (CNT_RAW > EIU_W) ? CNT_RAW : EIU_W;
  localparam int unsigned PROD_W = IDX_W + 1 + TPE_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [TPE_W-1:0]         tpe_q;
  logic [EIU_W-1:0]         eiu_q;
  logic [CACHE_ENTRIES-1:0] valid_q;

  key_t                     key_q;
  stamp_t                   now_q;
  logic [IDX_W-1:0]         last_q;
  logic [IDX_W-1:0]         rd_idx_q;

  logic                     cmp_vld_q;
  logic [IDX_W-1:0]         cmp_idx_q;
  logic                     cmp_valid_bit_q;

  logic                     hit_found_q, empty_found_q;
  logic [IDX_W-1:0]         hit_slot_q, empty_slot_q, victim_q;
  stamp_t                   best_age_q;

  logic                     done_q, hit_q;
  logic [IDX_W-1:0]         slot_q;
  logic [TIDX_W-1:0]        tidx_q;

  logic                     accept;
  logic [CNT_W-1:0]         n_ext, n_clamp;
  key_t                     key_rdata;
  stamp_t                   lu_rdata;
  stamp_t                   age;
  logic [IDX_W-1:0]         sel_slot;
  logic [PROD_W-1:0]        prod;
  logic                     scan_rd;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign busy_o  = (state_q != ST_IDLE);
  assign scan_rd = (state_q == ST_SCAN);

  // active slot count, saturated to the cache size, zero acts as one
  always_comb begin
    n_ext = CNT_W'(eiu_q);
    n_clamp = n_ext;
    if (n_ext > CNT_W'(CACHE_ENTRIES)) begin
      n_clamp = CNT_W'(CACHE_ENTRIES);
    end
    if (n_ext == '0) begin
      n_clamp = CNT_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpe_q <= TPE_RESET;
      eiu_q <= EIU_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TILES_PER_ENTRY: tpe_q <= TPE_W'(cfg_data_i);
        CFG_ENTRIES_IN_USE:  eiu_q <= EIU_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  tsc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_UPDATE) && !hit_found_q),
    .waddr_i (sel_slot),
    .wdata_i (key_q),
    .re_i    (scan_rd),
    .raddr_i (rd_idx_q),
    .rdata_o (key_rdata)
  );

  tsc_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_UPDATE),
    .waddr_i (sel_slot),
    .wdata_i (now_q),
    .re_i    (scan_rd),
    .raddr_i (rd_idx_q),
    .rdata_o (lu_rdata)
  );

  // shared compare unit: age of the slot read in the previous cycle
  assign age = now_q - lu_rdata;

  always_comb begin
    if (hit_found_q) begin
      sel_slot = hit_slot_q;
    end else if (empty_found_q) begin
      sel_slot = empty_slot_q;
    end else begin
      sel_slot = victim_q;
    end
  end

  assign prod = PROD_W'(PROD_W'(sel_slot) + PROD_W'(1)) * PROD_W'(tpe_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      valid_q       <= '0;
      rd_idx_q      <= '0;
      last_q        <= '0;
      cmp_vld_q     <= 1'b0;
      hit_found_q   <= 1'b0;
      empty_found_q <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= scan_rd;
      done_q    <= (state_q == ST_UPDATE);
      if (accept) begin
        rd_idx_q      <= '0;
        last_q        <= IDX_W'(n_clamp - CNT_W'(1));
        hit_found_q   <= 1'b0;
        empty_found_q <= 1'b0;
      end else begin
        if (scan_rd && (rd_idx_q != last_q)) begin
          rd_idx_q <= rd_idx_q + IDX_W'(1);
        end
        if (cmp_vld_q) begin
          if (cmp_valid_bit_q && (key_rdata == key_q) && !hit_found_q) begin
            hit_found_q <= 1'b1;
          end
          if (!cmp_valid_bit_q && !empty_found_q) begin
            empty_found_q <= 1'b1;
          end
        end
      end
      if (state_q == ST_UPDATE) begin
        valid_q[sel_slot] <= 1'b1;
      end
    end
  end

  // scan datapath and result registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q       <= rd_idx_q;
    cmp_valid_bit_q <= valid_q[rd_idx_q];
    if (accept) begin
      key_q      <= {glyph_i, colour_i, special_i, char_code_i, tile_number_i};
      now_q      <= now_i;
      best_age_q <= '0;
      victim_q   <= '0;
    end else if (cmp_vld_q) begin
      if (cmp_valid_bit_q && (key_rdata == key_q) && !hit_found_q) begin
        hit_slot_q <= cmp_idx_q;
      end
      if (!cmp_valid_bit_q && !empty_found_q) begin
        empty_slot_q <= cmp_idx_q;
      end
      // only positive ages compete, lowest slot wins a tie
      if (cmp_valid_bit_q && !empty_found_q && !age[STAMP_W-1] && (age > best_age_q)) begin
        best_age_q <= age;
        victim_q   <= cmp_idx_q;
      end
    end
    if (state_q == ST_UPDATE) begin
      hit_q  <= hit_found_q;
      slot_q <= sel_slot;
      tidx_q <= TIDX_W'(prod);
    end
  end

  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign slot_o       = SLOT_W'(slot_q);
  assign tile_index_o = tidx_q;

  a_done_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_UPDATE))
    else $error("result strobe without an update cycle");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted transaction did not start a scan");

  a_slot_now_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> valid_q[slot_q])
    else $error("chosen slot not marked valid");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (slot_q <= last_q))
    else $error("chosen slot beyond active slots");

  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> ((state_q == ST_SCAN) || (state_q == ST_DRAIN)))
    else $error("compare outside of scan");

endmodule

[tb/tb_tile_slot_cache_lru.sv]
// ----------------------------------------------------------------------------
// tb_tile_slot_cache_lru
// self-checking bench for the tile slot cache with timestamp lru replacement
// ----------------------------------------------------------------------------
// A directed table runs first. It covers reset values, key extremes, zero and
// maximum tiles per entry, active counts of zero and above the cache size,
// stamps from the future, and a full cache where no age is positive. Random
// lookups follow, drawn from a small key pool so that hits, fills and
// evictions all happen. Each phase has its own register setting and its own
// rate of sender idling. Results of typed rows are checked against fixed values,
// all others against a slot lookup model that the bench keeps itself.
module tb_tile_slot_cache_lru
  import tsc_pkg::*;
;

  typedef struct packed {
    logic [GLYPH_W-1:0]  glyph;
    logic [COLOUR_W-1:0] colour;
    logic [SPEC_W-1:0]   special;
    logic [CHAR_W-1:0]   char_code;
    logic [TILE_W-1:0]   tile_number;
    stamp_t              now;
  } lookup_req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [TIDX_W-1:0] tile_index;
  } slot_res_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    lookup_req_t           req;
    logic                  typed;
    slot_res_t             res;
  } dir_row_t;

  localparam int NumPhases = 7;
  localparam int PoolSize  = 256;
  localparam int MaxReports = 100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [GLYPH_W-1:0]    glyph_i;
  logic [COLOUR_W-1:0]   colour_i;
  logic [SPEC_W-1:0]     special_i;
  logic [CHAR_W-1:0]     char_code_i;
  logic [TILE_W-1:0]     tile_number_i;
  logic [STAMP_W-1:0]    now_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  done_o;
  logic                  hit_o;
  logic [SLOT_W-1:0]     slot_o;
  logic [TIDX_W-1:0]     tile_index_o;

  // lookup model state
  logic [TPE_W-1:0] mdl_tpe;
  logic [EIU_W-1:0] mdl_eiu;
  bit               slot_valid [CacheEntriesDef];
  key_t             slot_key   [CacheEntriesDef];
  stamp_t           slot_stamp [CacheEntriesDef];

  slot_res_t   slot_res_q [$];
  dir_row_t    dir_tab    [$];
  key_t        key_pool   [PoolSize];
  stamp_t      turn;

  int n_err;
  int n_hits;
  int n_misses;
  int n_writes;

  // per phase: tiles per entry write data, active slots, idle percent, lookups
  int ph_tpe   [NumPhases] = '{1, 16, 255, 7, 224, 5, 2};
  int ph_eiu   [NumPhases] = '{8, 3, 16, 128, 1, 255, 40};
  int ph_idle  [NumPhases] = '{0, 65, 0, 7, 65, 7, 30};
  int ph_count [NumPhases] = '{180, 180, 150, 200, 100, 40, 90};

  tile_slot_cache_lru dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .glyph_i      (glyph_i),
    .colour_i     (colour_i),
    .special_i    (special_i),
    .char_code_i  (char_code_i),
    .tile_number_i(tile_number_i),
    .now_i        (now_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .slot_o       (slot_o),
    .tile_index_o (tile_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned active_slots();
    int unsigned n;
    n = (mdl_eiu > CacheEntriesDef) ? CacheEntriesDef : mdl_eiu;
    if (n == 0) n = 1;
    return n;
  endfunction

  // search, fill or evict, then stamp the chosen slot
  function automatic slot_res_t lookup_slot(input lookup_req_t r);
    key_t        k;
    int unsigned n;
    int unsigned sl;
    int unsigned victim;
    int unsigned tidx;
    stamp_t      best;
    stamp_t      age;
    bit          found;
    bit          empty_found;
    slot_res_t   res;
    k = {r.glyph, r.colour, r.special, r.char_code, r.tile_number};
    n = active_slots();
    found = 1'b0;
    sl = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!found && slot_valid[i] && slot_key[i] == k) begin
        found = 1'b1;
        sl = i;
      end
    end
    if (!found) begin
      empty_found = 1'b0;
      best = '0;
      victim = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (!empty_found) begin
          if (!slot_valid[i]) begin
            empty_found = 1'b1;
            sl = i;
          end else begin
            // ages from the future read as negative and never compete
            age = r.now - slot_stamp[i];
            if (!age[STAMP_W-1] && age > best) begin
              best = age;
              victim = i;
            end
          end
        end
      end
      if (!empty_found) sl = victim;
      slot_valid[sl] = 1'b1;
      slot_key[sl] = k;
    end
    slot_stamp[sl] = r.now;
    tidx = (sl + 1) * mdl_tpe;
    res.hit = found;
    res.slot = sl[SLOT_W-1:0];
    res.tile_index = tidx[TIDX_W-1:0];
    return res;
  endfunction

  function automatic lookup_req_t mk_req(input int g, input int c, input int s, input int ch,
                                         input int t, input stamp_t now);
    lookup_req_t r;
    r.glyph = GLYPH_W'(g);
    r.colour = COLOUR_W'(c);
    r.special = SPEC_W'(s);
    r.char_code = CHAR_W'(ch);
    r.tile_number = TILE_W'(t);
    r.now = now;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic dir_row_t req_row(input lookup_req_t r);
    dir_row_t row;
    row = '0;
    row.req = r;
    return row;
  endfunction

  function automatic dir_row_t typed_row(input lookup_req_t r, input logic hit,
                                         input int sl, input int tidx);
    dir_row_t row;
    row = req_row(r);
    row.typed = 1'b1;
    row.res.hit = hit;
    row.res.slot = SLOT_W'(sl);
    row.res.tile_index = TIDX_W'(tidx);
    return row;
  endfunction

  // register write, only once every outstanding result is back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (slot_res_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TILES_PER_ENTRY) mdl_tpe = data[TPE_W-1:0];
    else mdl_eiu = data[EIU_W-1:0];
    n_writes++;
  endtask

  // gap > 0: start low for that many cycles; gap < 0: hold off until drained
  task automatic issue_lookup(input lookup_req_t r, input int gap);
    @(negedge clk_i);
    if (gap != 0) begin
      start_i <= 1'b0;
      if (gap < 0) begin
        while (slot_res_q.size() != 0) @(posedge clk_i);
      end else begin
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    glyph_i <= r.glyph;
    colour_i <= r.colour;
    special_i <= r.special;
    char_code_i <= r.char_code;
    tile_number_i <= r.tile_number;
    now_i <= r.now;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      if (n_err < MaxReports)
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      n_err++;
    end
  endtask

  // result checker
  slot_res_t mon_exp;
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (slot_res_q.size() == 0) begin
        if (n_err < MaxReports) $error("result with no transaction outstanding");
        n_err++;
      end else begin
        mon_exp = slot_res_q.pop_front();
        check_field("hit", mon_exp.hit, hit_o);
        check_field("slot", mon_exp.slot, slot_o);
        check_field("tile_index", mon_exp.tile_index, tile_index_o);
        if (hit_o) n_hits++;
        else n_misses++;
      end
    end
  end

  initial begin
    dir_row_t    row;
    lookup_req_t r;
    slot_res_t   res;
    int          gap;
    int unsigned psz;
    int unsigned roll;
    key_t        k;

    rst_ni = 1'b0;
    start_i = 1'b0;
    glyph_i = '0;
    colour_i = '0;
    special_i = '0;
    char_code_i = '0;
    tile_number_i = '0;
    now_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TILES_PER_ENTRY;
    cfg_data_i = '0;
    n_err = 0;
    n_hits = 0;
    n_misses = 0;
    n_writes = 0;
    mdl_tpe = TPE_RESET;
    mdl_eiu = EIU_RESET;
    for (int i = 0; i < CacheEntriesDef; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_stamp[i] = '0;
    end
    for (int i = 0; i < PoolSize; i++)
      key_pool[i] = key_t'({$urandom, $urandom});

    // reset values, key extremes, stamp wrap
    dir_tab.push_back(typed_row(mk_req(0, 0, 0, 0, 0, 32'h0), 1'b0, 0, 4));
    dir_tab.push_back(typed_row(mk_req(0, 0, 0, 0, 0, 32'h5), 1'b1, 0, 4));
    dir_tab.push_back(typed_row(mk_req(8191, 15, 255, 255, 4095, 32'hFFFF_FFFF), 1'b0, 1, 8));
    // zero tiles per entry, upper data bits dropped
    dir_tab.push_back(cfg_row(CFG_TILES_PER_ENTRY, 8'hE0));
    dir_tab.push_back(typed_row(mk_req(8191, 15, 255, 255, 4095, 32'h0), 1'b1, 1, 0));
    dir_tab.push_back(cfg_row(CFG_TILES_PER_ENTRY, 8'h1F));
    // two active slots: eviction by age, then no positive age picks slot 0
    dir_tab.push_back(cfg_row(CFG_ENTRIES_IN_USE, 8'd2));
    dir_tab.push_back(req_row(mk_req(1, 2, 3, 4, 5, 32'd10)));
    dir_tab.push_back(typed_row(mk_req(8191, 0, 8'hAA, 8'h55, 0, 32'd5), 1'b0, 0, 31));
    // age of exactly half the stamp range is negative
    dir_tab.push_back(req_row(mk_req(7, 9, 11, 13, 17, 32'h8000_0005)));
    // active count of zero acts as one, upper slots keep their contents
    dir_tab.push_back(cfg_row(CFG_ENTRIES_IN_USE, 8'd0));
    dir_tab.push_back(req_row(mk_req(8191, 0, 8'hAA, 8'h55, 0, 32'h8000_0005)));
    dir_tab.push_back(req_row(mk_req(4096, 8, 128, 128, 2048, 32'h8000_0006)));
    // count above the cache size saturates
    dir_tab.push_back(cfg_row(CFG_ENTRIES_IN_USE, 8'hFF));
    dir_tab.push_back(req_row(mk_req(7, 9, 11, 13, 17, 32'd7)));
    dir_tab.push_back(req_row(mk_req(100, 1, 2, 3, 4, 32'd7)));
    dir_tab.push_back(cfg_row(CFG_TILES_PER_ENTRY, 8'd16));
    dir_tab.push_back(cfg_row(CFG_ENTRIES_IN_USE, 8'd128));
    dir_tab.push_back(typed_row(mk_req(200, 6, 5, 4, 3, 32'd8), 1'b0, 3, 64));
    dir_tab.push_back(req_row(mk_req(8191, 15, 255, 255, 4095, 32'd9)));
    dir_tab.push_back(req_row(mk_req(0, 0, 0, 0, 0, 32'd9)));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        write_reg(row.idx, row.data);
      end else begin
        issue_lookup(row.req, 0);
        res = lookup_slot(row.req);
        slot_res_q.push_back(row.typed ? row.res : res);
      end
    end

    turn = $urandom;
    for (int p = 0; p < NumPhases; p++) begin
      write_reg(CFG_TILES_PER_ENTRY, CFG_DATA_W'(ph_tpe[p]));
      write_reg(CFG_ENTRIES_IN_USE, CFG_DATA_W'(ph_eiu[p]));
      // pool a bit larger than the active slots: mostly hits, steady evictions
      psz = active_slots() + active_slots() / 2 + 2;
      for (int j = 0; j < ph_count[p]; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) turn = turn + $urandom_range(0, 3);
        else if (roll < 92) turn = turn + $urandom_range(4, 1000);
        else if (roll < 97) turn = turn + $urandom_range(0, 32'h7FFF_FFFF);
        else turn = $urandom;
        if ($urandom_range(0, 9) == 0) k = key_t'({$urandom, $urandom});
        else k = key_pool[$urandom_range(0, psz - 1)];
        r = lookup_req_t'({k, turn});
        if ($urandom_range(0, 99) < 2) gap = -1;
        else if ($urandom_range(0, 99) < ph_idle[p])
          gap = $urandom_range(1, active_slots() + 5);
        else gap = 0;
        issue_lookup(r, gap);
        res = lookup_slot(r);
        slot_res_q.push_back(res);
      end
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (slot_res_q.size() != 0) @(posedge clk_i);
    repeat (2 * CacheEntriesDef + 8) @(posedge clk_i);

    $display("tile slot cache: %0d lookups checked, %0d hits, %0d fills or evictions",
             n_hits + n_misses, n_hits, n_misses);
    $display("%0d register writes, tiles per entry 0 to 31, active slots 1 to 128",
             n_writes);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
